// ===== hdl/ldr_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear phase deramp package
// Shared types, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package ldr_pkg;

    // Default sizing of the block.
    localparam int DEF_MAX_ROWS     = 64;
    localparam int DEF_MAX_COLS     = 64;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_CORDIC_STEPS = 16;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COL_COUNT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_MODE = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DERAMP_EN = 2'd3;

    // Axis mode codes.
    localparam logic [1:0] AXIS_ROW_ONLY = 2'd0;
    localparam logic [1:0] AXIS_COL_ONLY = 2'd1;
    localparam logic [1:0] AXIS_BOTH     = 2'd2;

    // Command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int SUM_BITS     = 48;
    localparam int TERM_BITS    = 34;
    localparam int ANGLE_BITS   = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int ITER_BITS    = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_MAC,
        ST_VEC_SETUP,
        ST_ITER,
        ST_VEC_DONE,
        ST_RD_MULX,
        ST_RD_MULY,
        ST_RD_FOLD,
        ST_RD_OUT
    } state_t;

    // Arctangent of 2^-i, 32 bits per turn.
    function automatic logic [31:0] atan_entry(input logic [ITER_BITS-1:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/linear_phase_deramp_unit.sv =====
// ----------------------------------------------------------------------------
// Linear phase deramp unit
// Stores a complex image, estimates its row and column phase steps and
// returns each pixel with the linear phase ramp rotated away.
// ----------------------------------------------------------------------------
// Use: every input transaction carries a command. A load (command 0) writes
// the next pixel in row-major order; a readout (command 1) returns the next
// stored pixel as one result transaction on the m_ channel. A load arriving
// while a complete image waits to be read is dropped, as is a readout issued
// before the image is complete.
// A load occupies the block while the shared multiplier forms the eight
// neighbour products one per cycle. The last load of an image occupies it
// further while the shared CORDIC turns both neighbour sums into step
// angles. A deramped readout passes through two gain multiplications, a
// quadrant fold, one CORDIC iteration per cycle and the output load. With
// deramping off a readout goes straight to the output load.
// The result sits in an output register, so the next input transaction is
// taken while the receiver stalls; a readout only waits for the register
// to drain at its final step.
// Reset (synchronous, active low) restores the register defaults, empties
// the image and clears both step angles; the pixel memory is not cleared.
// Writing row_count or col_count discards the image in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_phase_deramp_unit #(
    parameter int MAX_ROWS     = ldr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS     = ldr_pkg::DEF_MAX_COLS,
    parameter int SAMPLE_BITS  = ldr_pkg::DEF_SAMPLE_BITS,
    parameter int CORDIC_STEPS = ldr_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Configuration write port
    input  wire logic                                   cfg_wr_en,
    input  wire logic [ldr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [ldr_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    // Input channel
    input  wire logic                                   s_valid,
    output      logic                                   s_ready,
    input  wire logic                                   s_command,
    input  wire logic signed [SAMPLE_BITS-1:0]          s_sample_re,
    input  wire logic signed [SAMPLE_BITS-1:0]          s_sample_im,
    // Result channel
    output      logic                                   m_valid,
    input  wire logic                                   m_ready,
    output      logic signed [SAMPLE_BITS-1:0]          m_out_re,
    output      logic signed [SAMPLE_BITS-1:0]          m_out_im,
    output      logic                                   m_last_of_image
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CLW    = $clog2(MAX_COLS);
    localparam int RCW    = $clog2(MAX_ROWS + 1);
    localparam int CCW    = $clog2(MAX_COLS + 1);
    localparam int NSTEPS = (CORDIC_STEPS < ldr_pkg::ATAN_ENTRIES) ?
                            CORDIC_STEPS : ldr_pkg::ATAN_ENTRIES;
    localparam int NSH    = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
    localparam longint GAIN = 64'd652032874 + (64'd434688583 >> (2 * NSTEPS));
    localparam int SB     = ldr_pkg::SUM_BITS;
    localparam int TB     = ldr_pkg::TERM_BITS;
    localparam int AB     = ldr_pkg::ANGLE_BITS;
    localparam int IB     = ldr_pkg::ITER_BITS;
    localparam int ROW_RESET = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int COL_RESET = (MAX_COLS < 64) ? MAX_COLS : 64;
    localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint OUT_MIN = -OUT_MAX - 64'sd1;

    // Floors a sample to its top 16 bits.
    function automatic logic signed [15:0] narrow(input logic signed [SAMPLE_BITS-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        return 16'(w >>> NSH);
    endfunction

    function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                     input logic signed [TB-1:0] t);
        logic signed [SB:0] s;
        s = (SB+1)'(a) + (SB+1)'(t);
        if (s[SB] != s[SB-1]) begin
            return s[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end
        return s[SB-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< 29)) >>> 30;
        if (r > OUT_MAX) begin
            return SAMPLE_BITS'(OUT_MAX);
        end
        if (r < OUT_MIN) begin
            return SAMPLE_BITS'(OUT_MIN);
        end
        return SAMPLE_BITS'(r);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    ldr_pkg::state_t state_reg, state_next;

    logic [RCW-1:0]         row_count_reg, row_count_next;
    logic [CCW-1:0]         col_count_reg, col_count_next;
    logic [1:0]             axis_mode_reg, axis_mode_next;
    logic                   deramp_en_reg, deramp_en_next;

    logic                   full_reg, full_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [CLW-1:0]         col_reg, col_next;
    logic signed [SB-1:0]   row_sum_re_reg, row_sum_re_next;
    logic signed [SB-1:0]   row_sum_im_reg, row_sum_im_next;
    logic signed [SB-1:0]   col_sum_re_reg, col_sum_re_next;
    logic signed [SB-1:0]   col_sum_im_reg, col_sum_im_next;
    logic [AB-1:0]          row_step_reg, row_step_next;
    logic [AB-1:0]          col_step_reg, col_step_next;
    logic [AB-1:0]          row_base_reg, row_base_next;
    logic [AB-1:0]          pix_phase_reg, pix_phase_next;
    logic [3:0]             k_reg, k_next;
    logic [IB-1:0]          iter_reg, iter_next;
    logic                   axis_sel_reg, axis_sel_next;
    logic                   vec_mode_reg, vec_mode_next;
    logic                   m_valid_reg, m_valid_next;

    // Payload registers
    logic signed [15:0]     cur_re_reg, cur_re_next, cur_im_reg, cur_im_next;
    logic signed [15:0]     left_re_reg, left_re_next, left_im_reg, left_im_next;
    logic                   has_left_reg, has_left_next, has_up_reg, has_up_next;
    logic                   last_pix_reg, last_pix_next;
    logic signed [63:0]     prod_reg, prod_next;
    logic signed [TB-1:0]   term_reg, term_next;
    logic signed [63:0]     x_reg, x_next, y_reg, y_next;
    logic signed [TB-1:0]   z_reg, z_next;
    logic signed [SAMPLE_BITS-1:0] out_re_reg, out_re_next, out_im_reg, out_im_next;
    logic                   out_last_reg, out_last_next;

    // Pixel memory
    logic [2*SAMPLE_BITS-1:0] mem [DEPTH];
    logic [2*SAMPLE_BITS-1:0] rd_data_reg;
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;

    // ------------------------------------------------------------------
    // Decoded conditions
    // ------------------------------------------------------------------
    logic accept, load_go, read_go, out_free;
    logic col_last, row_last, mac_done, iter_done, axis_on, sum_zero, vec_finish;
    logic signed [SAMPLE_BITS-1:0] rd_re, rd_im;
    logic signed [15:0] up_re, up_im;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [SB-1:0] sel_sum_re, sel_sum_im;

    assign s_ready   = (state_reg == ldr_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign load_go   = accept && (s_command == ldr_pkg::CMD_LOAD) && !full_reg;
    assign read_go   = accept && (s_command == ldr_pkg::CMD_READ) && full_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign col_last  = (CCW'(col_reg) + CCW'(1)) == col_count_reg;
    assign row_last  = (RCW'(row_reg) + RCW'(1)) == row_count_reg;
    assign mac_done  = (k_reg == 4'd8);
    assign iter_done = (iter_reg == IB'(NSTEPS - 1));

    assign rd_re = rd_data_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign rd_im = rd_data_reg[SAMPLE_BITS-1:0];
    assign up_re = narrow(rd_re);
    assign up_im = narrow(rd_im);

    // An axis contributes only when the mode selects it and its sum is not empty.
    assign axis_on = axis_sel_reg ?
                     (axis_mode_reg != ldr_pkg::AXIS_ROW_ONLY && col_count_reg > CCW'(1)) :
                     (axis_mode_reg != ldr_pkg::AXIS_COL_ONLY && row_count_reg > RCW'(1));
    assign sel_sum_re = axis_sel_reg ? col_sum_re_reg : row_sum_re_reg;
    assign sel_sum_im = axis_sel_reg ? col_sum_im_reg : row_sum_im_reg;
    assign sum_zero   = (sel_sum_re == '0) && (sel_sum_im == '0);
    assign vec_finish = axis_sel_reg &&
                        (((state_reg == ldr_pkg::ST_VEC_SETUP) && (!axis_on || sum_zero)) ||
                         (state_reg == ldr_pkg::ST_VEC_DONE));

    // ------------------------------------------------------------------
    // Shared multiplier. During a load it forms the neighbour products in
    // the order re*re, im*im, im*re, re*im, first for the left neighbour and
    // then for the upper one; during a readout it applies the CORDIC gain.
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [15:0] ar, ai;
        ar = k_reg[2] ? up_re : left_re_reg;
        ai = k_reg[2] ? up_im : left_im_reg;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ldr_pkg::ST_LOAD_MAC: begin
                case (k_reg[1:0])
                    2'd0:    begin mul_a = 32'(ar); mul_b = 32'(cur_re_reg); end
                    2'd1:    begin mul_a = 32'(ai); mul_b = 32'(cur_im_reg); end
                    2'd2:    begin mul_a = 32'(ai); mul_b = 32'(cur_re_reg); end
                    default: begin mul_a = 32'(ar); mul_b = 32'(cur_im_reg); end
                endcase
            end
            ldr_pkg::ST_RD_MULX: begin
                mul_a = 32'(rd_re);
                mul_b = 32'(GAIN);
            end
            ldr_pkg::ST_RD_MULY: begin
                mul_a = 32'(rd_im);
                mul_b = 32'(GAIN);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ldr_pkg::ST_IDLE: begin
                if (load_go) begin
                    state_next = ldr_pkg::ST_LOAD_MAC;
                end else if (read_go) begin
                    state_next = deramp_en_reg ? ldr_pkg::ST_RD_MULX : ldr_pkg::ST_RD_OUT;
                end
            end
            ldr_pkg::ST_LOAD_MAC: begin
                if (mac_done) begin
                    state_next = last_pix_reg ? ldr_pkg::ST_VEC_SETUP : ldr_pkg::ST_IDLE;
                end
            end
            ldr_pkg::ST_VEC_SETUP: begin
                if (axis_on && !sum_zero) begin
                    state_next = ldr_pkg::ST_ITER;
                end else if (axis_sel_reg) begin
                    state_next = ldr_pkg::ST_IDLE;
                end
            end
            ldr_pkg::ST_ITER: begin
                if (iter_done) begin
                    state_next = vec_mode_reg ? ldr_pkg::ST_VEC_DONE : ldr_pkg::ST_RD_OUT;
                end
            end
            ldr_pkg::ST_VEC_DONE: begin
                state_next = axis_sel_reg ? ldr_pkg::ST_IDLE : ldr_pkg::ST_VEC_SETUP;
            end
            ldr_pkg::ST_RD_MULX: begin
                state_next = ldr_pkg::ST_RD_MULY;
            end
            ldr_pkg::ST_RD_MULY: begin
                state_next = ldr_pkg::ST_RD_FOLD;
            end
            ldr_pkg::ST_RD_FOLD: begin
                state_next = ldr_pkg::ST_ITER;
            end
            ldr_pkg::ST_RD_OUT: begin
                if (out_free) begin
                    state_next = ldr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ldr_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and bookkeeping
    // ------------------------------------------------------------------
    always_comb begin
        logic [2:0]            j;
        logic                  en;
        logic signed [TB-1:0]  pt;
        logic signed [63:0]    dx, dy;
        logic signed [TB-1:0]  at;
        logic                  up_dir;
        logic [31:0]           t;
        logic [31:0]           zr;
        logic [CCW-1:0]        cv;
        logic [RCW-1:0]        rv;

        row_count_next  = row_count_reg;
        col_count_next  = col_count_reg;
        axis_mode_next  = axis_mode_reg;
        deramp_en_next  = deramp_en_reg;
        full_next       = full_reg;
        ptr_next        = ptr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        row_sum_re_next = row_sum_re_reg;
        row_sum_im_next = row_sum_im_reg;
        col_sum_re_next = col_sum_re_reg;
        col_sum_im_next = col_sum_im_reg;
        row_step_next   = row_step_reg;
        col_step_next   = col_step_reg;
        row_base_next   = row_base_reg;
        pix_phase_next  = pix_phase_reg;
        k_next          = k_reg;
        iter_next       = iter_reg;
        axis_sel_next   = axis_sel_reg;
        vec_mode_next   = vec_mode_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cur_re_next     = cur_re_reg;
        cur_im_next     = cur_im_reg;
        left_re_next    = left_re_reg;
        left_im_next    = left_im_reg;
        has_left_next   = has_left_reg;
        has_up_next     = has_up_reg;
        last_pix_next   = last_pix_reg;
        prod_next       = prod_reg;
        term_next       = term_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        out_re_next     = out_re_reg;
        out_im_next     = out_im_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        rd_addr         = ptr_reg;

        j      = k_reg[2:0] - 3'd1;
        en     = j[2] ? has_up_reg : has_left_reg;
        pt     = TB'(prod_reg);
        dx     = y_reg >>> iter_reg;
        dy     = x_reg >>> iter_reg;
        at     = TB'(ldr_pkg::atan_entry(iter_reg));
        up_dir = vec_mode_reg ? !y_reg[63] : z_reg[TB-1];
        t      = {pix_phase_reg, 16'h0000};
        zr     = z_reg[31:0] + 32'h0000_8000;
        cv     = '0;
        rv     = '0;

        case (state_reg)
            ldr_pkg::ST_IDLE: begin
                if (load_go) begin
                    mem_we        = 1'b1;
                    rd_addr       = ptr_reg - AW'(col_count_reg);
                    cur_re_next   = narrow(s_sample_re);
                    cur_im_next   = narrow(s_sample_im);
                    has_left_next = (col_reg != '0);
                    has_up_next   = (row_reg != '0);
                    last_pix_next = col_last && row_last;
                    k_next        = '0;
                    ptr_next      = ptr_reg + AW'(1);
                    if (col_last) begin
                        col_next = '0;
                        row_next = row_reg + RW'(1);
                    end else begin
                        col_next = col_reg + CLW'(1);
                    end
                end
            end
            ldr_pkg::ST_LOAD_MAC: begin
                if (!mac_done) begin
                    prod_next = mul_p;
                end
                if (k_reg != 4'd0) begin
                    case (j[1:0])
                        2'd0, 2'd2: begin
                            term_next = pt;
                        end
                        2'd1: begin
                            if (en && j[2]) begin
                                row_sum_re_next = sat_add(row_sum_re_reg, term_reg + pt);
                            end else if (en) begin
                                col_sum_re_next = sat_add(col_sum_re_reg, term_reg + pt);
                            end
                        end
                        default: begin
                            if (en && j[2]) begin
                                row_sum_im_next = sat_add(row_sum_im_reg, term_reg - pt);
                            end else if (en) begin
                                col_sum_im_next = sat_add(col_sum_im_reg, term_reg - pt);
                            end
                        end
                    endcase
                end
                k_next = k_reg + 4'd1;
                if (mac_done) begin
                    left_re_next  = cur_re_reg;
                    left_im_next  = cur_im_reg;
                    axis_sel_next = 1'b0;
                end
            end
            ldr_pkg::ST_VEC_SETUP: begin
                vec_mode_next = 1'b1;
                iter_next     = '0;
                if (!axis_on || sum_zero) begin
                    if (axis_sel_reg) begin
                        col_step_next = '0;
                    end else begin
                        row_step_next = '0;
                        axis_sel_next = 1'b1;
                    end
                end else if (sel_sum_re[SB-1]) begin
                    // Left half-plane: mirror through the origin, add half a turn.
                    x_next = -64'(sel_sum_re);
                    y_next = -64'(sel_sum_im);
                    z_next = TB'(34'h0_8000_0000);
                end else begin
                    x_next = 64'(sel_sum_re);
                    y_next = 64'(sel_sum_im);
                    z_next = '0;
                end
            end
            ldr_pkg::ST_ITER: begin
                if (up_dir) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                iter_next = iter_reg + IB'(1);
            end
            ldr_pkg::ST_VEC_DONE: begin
                if (axis_sel_reg) begin
                    col_step_next = zr[31:16];
                end else begin
                    row_step_next = zr[31:16];
                    axis_sel_next = 1'b1;
                end
            end
            ldr_pkg::ST_RD_MULX: begin
                prod_next     = mul_p;
                vec_mode_next = 1'b0;
            end
            ldr_pkg::ST_RD_MULY: begin
                x_next    = prod_reg;
                prod_next = mul_p;
            end
            ldr_pkg::ST_RD_FOLD: begin
                iter_next = '0;
                // Phases in the back half-turn are folded by negating the sample.
                if ((t + 32'h4000_0000) >= 32'h8000_0000) begin
                    x_next = -x_reg;
                    y_next = -prod_reg;
                    z_next = TB'($signed(t - 32'h8000_0000));
                end else begin
                    y_next = prod_reg;
                    z_next = TB'($signed(t));
                end
            end
            ldr_pkg::ST_RD_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_re_next   = deramp_en_reg ? round_sat(x_reg) : rd_re;
                    out_im_next   = deramp_en_reg ? round_sat(y_reg) : rd_im;
                    out_last_next = col_last && row_last;
                    ptr_next      = ptr_reg + AW'(1);
                    if (col_last) begin
                        col_next       = '0;
                        row_next       = row_reg + RW'(1);
                        row_base_next  = row_base_reg + row_step_reg;
                        pix_phase_next = row_base_reg + row_step_reg;
                    end else begin
                        col_next       = col_reg + CLW'(1);
                        pix_phase_next = pix_phase_reg + col_step_reg;
                    end
                    if (col_last && row_last) begin
                        full_next       = 1'b0;
                        ptr_next        = '0;
                        row_next        = '0;
                        col_next        = '0;
                        row_sum_re_next = '0;
                        row_sum_im_next = '0;
                        col_sum_re_next = '0;
                        col_sum_im_next = '0;
                    end
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase

        // Both step angles are known: the image is ready for readout.
        if (vec_finish) begin
            full_next      = 1'b1;
            ptr_next       = '0;
            row_next       = '0;
            col_next       = '0;
            row_base_next  = '0;
            pix_phase_next = '0;
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                ldr_pkg::REG_ROW_COUNT, ldr_pkg::REG_COL_COUNT: begin
                    if (cfg_index == ldr_pkg::REG_ROW_COUNT) begin
                        if (cfg_wdata == '0) begin
                            rv = RCW'(1);
                        end else if (32'(cfg_wdata) > MAX_ROWS) begin
                            rv = RCW'(MAX_ROWS);
                        end else begin
                            rv = RCW'(cfg_wdata);
                        end
                        row_count_next = rv;
                    end else begin
                        if (cfg_wdata == '0) begin
                            cv = CCW'(1);
                        end else if (32'(cfg_wdata) > MAX_COLS) begin
                            cv = CCW'(MAX_COLS);
                        end else begin
                            cv = CCW'(cfg_wdata);
                        end
                        col_count_next = cv;
                    end
                    full_next       = 1'b0;
                    ptr_next        = '0;
                    row_next        = '0;
                    col_next        = '0;
                    row_sum_re_next = '0;
                    row_sum_im_next = '0;
                    col_sum_re_next = '0;
                    col_sum_im_next = '0;
                end
                ldr_pkg::REG_AXIS_MODE: begin
                    axis_mode_next = cfg_wdata[1:0];
                end
                ldr_pkg::REG_DERAMP_EN: begin
                    deramp_en_next = cfg_wdata[0];
                end
                default: begin
                    axis_mode_next = axis_mode_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ldr_pkg::ST_IDLE;
            row_count_reg  <= RCW'(ROW_RESET);
            col_count_reg  <= CCW'(COL_RESET);
            axis_mode_reg  <= ldr_pkg::AXIS_BOTH;
            deramp_en_reg  <= 1'b1;
            full_reg       <= 1'b0;
            ptr_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            row_sum_re_reg <= '0;
            row_sum_im_reg <= '0;
            col_sum_re_reg <= '0;
            col_sum_im_reg <= '0;
            row_step_reg   <= '0;
            col_step_reg   <= '0;
            row_base_reg   <= '0;
            pix_phase_reg  <= '0;
            k_reg          <= '0;
            iter_reg       <= '0;
            axis_sel_reg   <= 1'b0;
            vec_mode_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            axis_mode_reg  <= axis_mode_next;
            deramp_en_reg  <= deramp_en_next;
            full_reg       <= full_next;
            ptr_reg        <= ptr_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            row_sum_re_reg <= row_sum_re_next;
            row_sum_im_reg <= row_sum_im_next;
            col_sum_re_reg <= col_sum_re_next;
            col_sum_im_reg <= col_sum_im_next;
            row_step_reg   <= row_step_next;
            col_step_reg   <= col_step_next;
            row_base_reg   <= row_base_next;
            pix_phase_reg  <= pix_phase_next;
            k_reg          <= k_next;
            iter_reg       <= iter_next;
            axis_sel_reg   <= axis_sel_next;
            vec_mode_reg   <= vec_mode_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cur_re_reg   <= cur_re_next;
        cur_im_reg   <= cur_im_next;
        left_re_reg  <= left_re_next;
        left_im_reg  <= left_im_next;
        has_left_reg <= has_left_next;
        has_up_reg   <= has_up_next;
        last_pix_reg <= last_pix_next;
        prod_reg     <= prod_next;
        term_reg     <= term_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        out_re_reg   <= out_re_next;
        out_im_reg   <= out_im_next;
        out_last_reg <= out_last_next;
    end

    // Pixel memory: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ptr_reg] <= {s_sample_re, s_sample_im};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_re        = out_re_reg;
    assign m_out_im        = out_im_reg;
    assign m_last_of_image = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_read_needs_image: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ldr_pkg::ST_RD_MULX || state_reg == ldr_pkg::ST_RD_MULY ||
         state_reg == ldr_pkg::ST_RD_FOLD || state_reg == ldr_pkg::ST_RD_OUT) |-> full_reg)
        else $error("readout in progress without a complete image");

    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ldr_pkg::ST_ITER) |-> (iter_reg < IB'(NSTEPS)))
        else $error("CORDIC iteration count out of range");

    a_dropped_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == ldr_pkg::CMD_LOAD && full_reg && !cfg_wr_en)
        |=> ($stable(ptr_reg) && state_reg == ldr_pkg::ST_IDLE))
        else $error("load into a complete image changed the image");

    a_result_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ldr_pkg::ST_RD_OUT && out_free) |=> m_valid_reg)
        else $error("readout finished without a result");

endmodule

`default_nettype wire

// ===== test/ldr_checker.sv =====
// ----------------------------------------------------------------------------
// Linear phase deramp checker
// Watches the configuration port and both channels, predicts every result
// transaction of the deramp unit and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldr_checker (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [ldr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [ldr_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  wire logic                                   s_valid,
    input  wire logic                                   s_ready,
    input  wire logic                                   s_command,
    input  wire logic signed [15:0]                     s_sample_re,
    input  wire logic signed [15:0]                     s_sample_im,
    input  wire logic                                   m_valid,
    input  wire logic                                   m_ready,
    input  wire logic signed [15:0]                     m_out_re,
    input  wire logic signed [15:0]                     m_out_im,
    input  wire logic                                   m_last_of_image,
    output int                                          fail_count,
    output int                                          pending
);

    localparam int  DIM_MAX   = ldr_pkg::DEF_MAX_ROWS;
    localparam int  STEPS     = ldr_pkg::DEF_CORDIC_STEPS;
    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
    } pixel_result_t;

    pixel_result_t corrected_q[$];

    bit [31:0] arctan_turns [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic signed [15:0] img_re [DIM_MAX*DIM_MAX];
    logic signed [15:0] img_im [DIM_MAX*DIM_MAX];
    longint    rsum_re, rsum_im, csum_re, csum_im;
    bit [15:0] row_step, col_step;
    int        wr_ptr, rd_ptr;
    bit        img_full;
    int        n_rows, n_cols;
    bit [1:0]  mode;
    bit        derotate;

    function automatic longint clamp_acc(input longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    // Accumulate a * conj(b) into the given sum pair.
    task automatic add_product(inout longint sr, inout longint si, input int a, input int b);
        longint ar, ai, br, bi;
        ar = img_re[a]; ai = img_im[a];
        br = img_re[b]; bi = img_im[b];
        sr = clamp_acc(sr + ar * br + ai * bi);
        si = clamp_acc(si + ai * br - ar * bi);
    endtask

    function automatic bit [15:0] phase_of(input longint x, input longint y);
        bit [31:0] z;
        bit [31:0] zr;
        longint    dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 16'h0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_turns[i];
            end else begin
                x -= dx; y += dy; z -= arctan_turns[i];
            end
        end
        zr = z + 32'h8000;
        return zr[31:16];
    endfunction

    function automatic logic signed [15:0] round_q15(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 29)) >>> 30;
        if (r > 32767) return 16'sh7FFF;
        if (r < -32768) return -16'sh8000;
        return r[15:0];
    endfunction

    // Rotate a pixel by the given phase, with the CORDIC gain compensated.
    task automatic spin_pixel(input longint re, input longint im, input bit [15:0] phase,
                              output logic signed [15:0] ore, output logic signed [15:0] oim);
        longint    gain, x, y, z, dx, dy;
        bit [31:0] t;
        gain = 652032874 + longint'(64'd434688583 >> (2 * STEPS));
        x = re * gain;
        y = im * gain;
        t = {phase, 16'h0};
        if (((t + 32'h40000000) & 32'h80000000) != 0) begin
            x = -x;
            y = -y;
            t -= 32'h80000000;
        end
        z = longint'(int'(t));
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(arctan_turns[i]);
            end else begin
                x += dx; y -= dy; z += longint'(arctan_turns[i]);
            end
        end
        ore = round_q15(x);
        oim = round_q15(y);
    endtask

    task automatic drop_image();
        rsum_re = 0; rsum_im = 0; csum_re = 0; csum_im = 0;
        wr_ptr = 0;
        rd_ptr = 0;
        img_full = 0;
    endtask

    task automatic restore_defaults();
        row_step = 0;
        col_step = 0;
        n_rows = 64;
        n_cols = 64;
        mode = ldr_pkg::AXIS_BOTH;
        derotate = 1;
        drop_image();
    endtask

    function automatic int clamp_dim(input logic [6:0] v);
        if (v == 0) return 1;
        if (v > DIM_MAX) return DIM_MAX;
        return v;
    endfunction

    task automatic write_register(input logic [ldr_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [6:0] val);
        case (idx)
            ldr_pkg::REG_ROW_COUNT: begin
                n_rows = clamp_dim(val);
                drop_image();
            end
            ldr_pkg::REG_COL_COUNT: begin
                n_cols = clamp_dim(val);
                drop_image();
            end
            ldr_pkg::REG_AXIS_MODE: mode = val[1:0];
            ldr_pkg::REG_DERAMP_EN: derotate = val[0];
            default: ;
        endcase
    endtask

    // Works out what one accepted input transaction does to the image.
    task automatic take_command(input logic cmd, input logic signed [15:0] re,
                                input logic signed [15:0] im);
        int            size, p, row, col;
        bit [31:0]     ph;
        pixel_result_t res;
        size = n_rows * n_cols;
        if (cmd == ldr_pkg::CMD_LOAD) begin
            if (img_full || wr_ptr >= size) return;
            p = wr_ptr;
            img_re[p] = re;
            img_im[p] = im;
            if (p % n_cols != 0) add_product(csum_re, csum_im, p - 1, p);
            if (p >= n_cols) add_product(rsum_re, rsum_im, p - n_cols, p);
            wr_ptr = p + 1;
            if (wr_ptr == size) begin
                row_step = (mode != ldr_pkg::AXIS_COL_ONLY && n_rows > 1) ?
                           phase_of(rsum_re, rsum_im) : 16'h0;
                col_step = (mode != ldr_pkg::AXIS_ROW_ONLY && n_cols > 1) ?
                           phase_of(csum_re, csum_im) : 16'h0;
                img_full = 1;
                rd_ptr = 0;
            end
        end else begin
            if (!img_full || rd_ptr >= size) return;
            p = rd_ptr;
            res.re = img_re[p];
            res.im = img_im[p];
            res.last = (p == size - 1);
            if (derotate) begin
                row = p / n_cols;
                col = p % n_cols;
                ph = row * row_step + col * col_step;
                spin_pixel(img_re[p], img_im[p], ph[15:0], res.re, res.im);
            end
            corrected_q.push_back(res);
            rd_ptr = p + 1;
            if (res.last) drop_image();
        end
    endtask

    task automatic report(input string field, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        pixel_result_t want;
        if (!aresetn) begin
            restore_defaults();
            corrected_q.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (corrected_q.size() == 0) begin
                    report("unexpected result", m_out_re, 0);
                end else begin
                    want = corrected_q.pop_front();
                    if (m_out_re !== want.re) report("out_re", m_out_re, want.re);
                    if (m_out_im !== want.im) report("out_im", m_out_im, want.im);
                    if (m_last_of_image !== want.last)
                        report("last_of_image", m_last_of_image, want.last);
                end
            end
            if (cfg_wr_en) write_register(cfg_index, cfg_wdata);
            if (s_valid && s_ready) take_command(s_command, s_sample_re, s_sample_im);
        end
        pending = corrected_q.size();
    end

endmodule

// ===== test/linear_phase_deramp_unit_test.sv =====
// ----------------------------------------------------------------------------
// Linear phase deramp unit testbench
// Loads images of many shapes and contents, reads them back deramped or
// passed through, and lets the checker judge every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_phase_deramp_unit_test;

    // Content styles for loaded pixels.
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_EXTREME = 1;
    localparam int FILL_ZERO    = 2;
    localparam int FILL_SMALL   = 3;

    // The unused axis mode code, which the block treats as both axes.
    localparam logic [1:0] AXIS_SPARE = 2'd3;

    localparam int ITEM_TARGET = 750;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [ldr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [ldr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic                               s_command = ldr_pkg::CMD_LOAD;
    logic signed [15:0]                 s_sample_re = '0;
    logic signed [15:0]                 s_sample_im = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic signed [15:0]                 m_out_re;
    logic signed [15:0]                 m_out_im;
    logic                               m_last_of_image;
    int                                 fail_count;
    int                                 pending;

    int sent_count = 0;
    int burst_left = 0;

    linear_phase_deramp_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_sample_re     (s_sample_re),
        .s_sample_im     (s_sample_im),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_re        (m_out_re),
        .m_out_im        (m_out_im),
        .m_last_of_image (m_last_of_image)
    );

    ldr_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_sample_re     (s_sample_re),
        .s_sample_im     (s_sample_im),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_re        (m_out_re),
        .m_out_im        (m_out_im),
        .m_last_of_image (m_last_of_image),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // The receiver stalls in runs of random length. Once, after some results
    // have gone through, it holds off for a long stretch so that the output
    // register fills and the block has to refuse further transactions.
    always @(posedge aclk) begin
        static int  hold_left = 0;
        static int  run_left = 0;
        static bit  run_ready = 1'b1;
        static bit  held = 1'b0;
        static int  taken = 0;
        if (m_valid && m_ready) taken++;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (taken >= 40 && !held) begin
                held = 1'b1;
                hold_left = 400;
            end
            if (run_left == 0) begin
                run_left = $urandom_range(1, 20);
                run_ready = ($urandom_range(0, 3) != 0);
            end
            run_left--;
            m_ready <= run_ready && (hold_left == 0);
        end
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one transaction and returns at the edge where it is accepted.
    // The sender works in bursts; between bursts valid may drop for a while.
    task automatic send_item(input logic cmd, input logic signed [15:0] re,
                             input logic signed [15:0] im);
        int gap;
        bit took;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_sample_re <= re;
        s_sample_im <= im;
        // Ready is sampled mid-cycle, where it is settled for the next edge.
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        sent_count++;
    endtask

    // Lets every expected result drain, then allows for work that produces
    // no result (a final load with both angle computations) to finish.
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_config(input logic [6:0] rows, input logic [6:0] cols,
                              input logic [1:0] axis, input logic enable);
        cfg_wr_en <= 1'b1;
        cfg_index <= ldr_pkg::REG_ROW_COUNT;
        cfg_wdata <= rows;
        @(posedge aclk);
        cfg_index <= ldr_pkg::REG_COL_COUNT;
        cfg_wdata <= cols;
        @(posedge aclk);
        cfg_index <= ldr_pkg::REG_AXIS_MODE;
        cfg_wdata <= {5'd0, axis};
        @(posedge aclk);
        cfg_index <= ldr_pkg::REG_DERAMP_EN;
        cfg_wdata <= {6'd0, enable};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_sample(input int fill);
        case (fill)
            FILL_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return -16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    3: return -16'sh0001;
                    default: return 16'sh0001;
                endcase
            end
            FILL_ZERO:  return 16'sh0000;
            FILL_SMALL: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic int effective_dim(input logic [6:0] v);
        if (v == 0) return 1;
        if (v > 64) return 64;
        return v;
    endfunction

    // One whole image: configure, load, then read it all back. With noise on,
    // readouts are slipped in before the image is complete (no result) and
    // surplus loads are offered once it is complete (ignored).
    task automatic run_image(input logic [6:0] rows, input logic [6:0] cols,
                             input logic [1:0] axis, input logic enable,
                             input int fill, input bit noise);
        int size;
        wait_idle();
        set_config(rows, cols, axis, enable);
        size = effective_dim(rows) * effective_dim(cols);
        for (int p = 0; p < size; p++) begin
            if (noise && $urandom_range(0, 7) == 0)
                send_item(ldr_pkg::CMD_READ, pick_sample(FILL_RANDOM),
                          pick_sample(FILL_RANDOM));
            send_item(ldr_pkg::CMD_LOAD, pick_sample(fill), pick_sample(fill));
        end
        if (noise) begin
            repeat ($urandom_range(1, 2))
                send_item(ldr_pkg::CMD_LOAD, pick_sample(FILL_RANDOM),
                          pick_sample(FILL_RANDOM));
        end
        for (int p = 0; p < size; p++)
            send_item(ldr_pkg::CMD_READ, pick_sample(FILL_RANDOM), pick_sample(FILL_RANDOM));
    endtask

    function automatic logic [6:0] pick_dim();
        if ($urandom_range(0, 15) != 0) return 7'($urandom_range(1, 6));
        case ($urandom_range(0, 3))
            0: return 7'd0;
            1: return 7'd127;
            2: return 7'd64;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    initial begin
        logic [6:0] rows, cols;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A readout with no image loaded yields nothing.
        send_item(ldr_pkg::CMD_READ, 16'sh7FFF, -16'sh8000);
        run_image(7'd2, 7'd3, ldr_pkg::AXIS_BOTH, 1'b1, FILL_EXTREME, 1'b0);
        // An all-zero image gives zero sums and so zero step angles.
        run_image(7'd3, 7'd2, ldr_pkg::AXIS_ROW_ONLY, 1'b1, FILL_ZERO, 1'b0);
        run_image(7'd2, 7'd2, ldr_pkg::AXIS_COL_ONLY, 1'b0, FILL_RANDOM, 1'b1);

        // A partly loaded image is thrown away by the next size write.
        wait_idle();
        set_config(7'd3, 7'd3, ldr_pkg::AXIS_BOTH, 1'b1);
        send_item(ldr_pkg::CMD_LOAD, 16'sh1234, -16'sh4321);
        send_item(ldr_pkg::CMD_LOAD, -16'sh8000, 16'sh7FFF);
        run_image(7'd1, 7'd1, AXIS_SPARE, 1'b1, FILL_EXTREME, 1'b0);

        // Out-of-range sizes clamp to the limits of the store.
        run_image(7'd0, 7'd127, AXIS_SPARE, 1'b1, FILL_RANDOM, 1'b0);
        run_image(7'd127, 7'd1, ldr_pkg::AXIS_BOTH, 1'b1, FILL_SMALL, 1'b0);

        while (sent_count < ITEM_TARGET) begin
            rows = pick_dim();
            cols = pick_dim();
            if (effective_dim(rows) * effective_dim(cols) > 64) cols = 7'd1;
            run_image(rows, cols, 2'($urandom_range(0, 3)),
                      $urandom_range(0, 3) != 0, $urandom_range(0, 3),
                      $urandom_range(0, 3) == 0);
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
